>>> hdl/r2fft_pkg.sv
// Shared types, constants and twiddle lookup for the radix-2 FFT unit.
package r2fft_pkg;

  localparam int POINTS_DEFAULT = 64;

  typedef struct packed {
    logic signed [15:0] sample_real;
    logic signed [15:0] sample_imag;
  } sample_t;

  typedef struct packed {
    logic signed [23:0] bin_real;
    logic signed [23:0] bin_imag;
    logic               last_bin;
  } bin_t;

  typedef struct packed {
    logic signed [23:0] re;
    logic signed [23:0] im;
  } cplx_t;

  localparam logic signed [15:0] QSIN [0:16] = '{
    16'sd0, 16'sd3212, 16'sd6393, 16'sd9512, 16'sd12540, 16'sd15447, 16'sd18205,
    16'sd20788, 16'sd23170, 16'sd25330, 16'sd27246, 16'sd28899, 16'sd30274,
    16'sd31357, 16'sd32138, 16'sd32610, 16'sd32767
  };

  // Sine of 2*pi*t/64 in Q1.15 built from the quarter-wave table.
  function automatic logic signed [15:0] sine64(input logic [5:0] t);
    logic [4:0] fwd;
    logic [4:0] rev;
    fwd = {1'b0, t[3:0]};
    rev = 5'd16 - fwd;
    case (t[5:4])
      2'd0: sine64 = QSIN[fwd];
      2'd1: sine64 = QSIN[rev];
      2'd2: sine64 = -QSIN[fwd];
      default: sine64 = -QSIN[rev];
    endcase
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
    if (v > 27'sd8388607) begin
      sat24 = 24'sh7FFFFF;
    end else if (v < -27'sd8388608) begin
      sat24 = 24'sh800000;
    end else begin
      sat24 = v[23:0];
    end
  endfunction

endpackage

>>> hdl/r2fft_cell.sv
// One decimation-in-time stage: twiddle multiply, delay line and butterfly.
module r2fft_cell #(
  parameter int POINTS = r2fft_pkg::POINTS_DEFAULT,
  parameter int HALF   = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              inv,
  input  logic              in_valid,
  input  r2fft_pkg::cplx_t  in_data,
  output logic              out_valid,
  output r2fft_pkg::cplx_t  out_data
);

  localparam int S  = $clog2(HALF);
  localparam int KW = $clog2(POINTS) + 1;

  logic [S:0]    kf;
  logic [5:0]    tw_idx;
  logic signed [15:0] wr;
  logic signed [15:0] sn;
  logic signed [15:0] wi;

  // Product register stage.
  logic               pv;
  logic               phi;
  r2fft_pkg::cplx_t   px;
  logic signed [39:0] pr1, pr2, pi1, pi2;

  // Delay line core.
  r2fft_pkg::cplx_t   dly [0:HALF-1];
  logic [KW-1:0]      kc;
  logic               drain;
  logic [S:0]         dcnt;

  logic signed [40:0] sum_re, sum_im;
  logic signed [40:0] rnd_re, rnd_im;
  logic signed [26:0] a_re, a_im, p_re, p_im;
  r2fft_pkg::cplx_t   head, push_val, out_next;
  logic               shift_en, out_valid_next;

  always_comb begin
    tw_idx = 6'((32'(kf) % HALF) << (5 - S));
    wr = r2fft_pkg::sine64(tw_idx + 6'd16);
    sn = r2fft_pkg::sine64(tw_idx);
    wi = inv ? sn : -sn;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kf <= '0;
      pv <= 1'b0;
    end else begin
      pv <= in_valid;
      if (in_valid) begin
        kf <= kf + 1'b1;
      end
    end
    phi <= kf[S];
    px  <= in_data;
    pr1 <= in_data.re * wr;
    pr2 <= in_data.im * wi;
    pi1 <= in_data.re * wi;
    pi2 <= in_data.im * wr;
  end

  always_comb begin
    head   = dly[HALF-1];
    sum_re = 41'(pr1) - 41'(pr2);
    sum_im = 41'(pi1) + 41'(pi2);
    rnd_re = sum_re + 41'sd16384;
    rnd_im = sum_im + 41'sd16384;
    p_re   = 27'(signed'(rnd_re[40:15]));
    p_im   = 27'(signed'(rnd_im[40:15]));
    a_re   = 27'(head.re);
    a_im   = 27'(head.im);
    shift_en = pv || drain;
    push_val = px;
    out_next = head;
    out_valid_next = 1'b0;
    if (pv && phi) begin
      out_next.re = r2fft_pkg::sat24(a_re + p_re);
      out_next.im = r2fft_pkg::sat24(a_im + p_im);
      push_val.re = r2fft_pkg::sat24(a_re - p_re);
      push_val.im = r2fft_pkg::sat24(a_im - p_im);
      out_valid_next = 1'b1;
    end else if (pv) begin
      // The first block of each frame only fills the delay line.
      out_valid_next = (kc >= KW'(2 * HALF));
    end else if (drain) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      dly[0] <= push_val;
      for (int i = 1; i < HALF; i++) begin
        dly[i] <= dly[i-1];
      end
    end
    out_data <= out_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kc        <= '0;
      drain     <= 1'b0;
      dcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (pv) begin
        if (kc == KW'(POINTS - 1)) begin
          kc    <= '0;
          drain <= 1'b1;
          dcnt  <= '0;
        end else begin
          kc <= kc + 1'b1;
        end
      end else if (drain) begin
        if (dcnt == (S+1)'(HALF - 1)) begin
          drain <= 1'b0;
        end
        dcnt <= dcnt + 1'b1;
      end
    end
  end

endmodule

>>> hdl/radix2_fft_complex_unit.sv
// Top level of the radix-2 FFT unit: sample loading, stage chain and bin output.
//
// Usage: pulse start with a sample while busy is low; each such transaction
// loads one complex sample. Samples are written to a reorder memory at the
// bit-reversed address. The transaction carrying the last sample of a frame
// raises busy and latches inverse_mode for the whole transform.
// The memory is then read out in order, one word a cycle, into a chain of
// log2(POINTS) stage cells. Stage s holds a delay line of 2^s entries and
// one butterfly, so every cell does one butterfly or one pass-through a cycle.
// The first bin appears after the read-out pass and the stage delay lines,
// and bins follow on consecutive cycles in natural order, one per
// strobe, with last_bin on the final one. Busy falls after that bin.
// The result cannot be held off; each bin is valid for exactly one cycle.
// Reset clears the load count, the mode register and all control state.
// cfg_write with cfg_data sets inverse_mode; write it only while idle.
module radix2_fft_complex_unit #(
  parameter int POINTS = r2fft_pkg::POINTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  r2fft_pkg::sample_t  sample,
  output logic                busy,
  input  logic                cfg_write,
  input  logic                cfg_data,
  output logic                strobe,
  output r2fft_pkg::bin_t     result
);

  localparam int LOG = $clog2(POINTS);

  logic            inverse_mode;
  logic            frame_inv;
  logic [LOG-1:0]  load_count;
  logic [LOG-1:0]  wr_addr;
  logic [LOG-1:0]  rd_cnt;
  logic [LOG-1:0]  out_cnt;
  logic            reading;
  logic            rd_valid;
  logic [31:0]     rd_word;
  logic [31:0]     store [0:POINTS-1];
  logic            accept;

  logic             cv [0:LOG];
  r2fft_pkg::cplx_t cd [0:LOG];

  assign accept = start && !busy;

  for (genvar i = 0; i < LOG; i++) begin : g_rev
    assign wr_addr[i] = load_count[LOG-1-i];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      store[wr_addr] <= sample;
    end
    rd_word <= store[rd_cnt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_mode <= 1'b0;
      frame_inv    <= 1'b0;
      load_count   <= '0;
      busy         <= 1'b0;
      reading      <= 1'b0;
      rd_cnt       <= '0;
      rd_valid     <= 1'b0;
      out_cnt      <= '0;
      strobe       <= 1'b0;
    end else begin
      if (cfg_write) begin
        inverse_mode <= cfg_data;
      end
      rd_valid <= reading;
      if (accept) begin
        load_count <= load_count + 1'b1;
        if (load_count == LOG'(POINTS - 1)) begin
          busy      <= 1'b1;
          reading   <= 1'b1;
          rd_cnt    <= '0;
          frame_inv <= inverse_mode;
        end
      end
      if (reading) begin
        rd_cnt <= rd_cnt + 1'b1;
        if (rd_cnt == LOG'(POINTS - 1)) begin
          reading <= 1'b0;
        end
      end
      strobe <= cv[LOG];
      if (cv[LOG]) begin
        out_cnt <= out_cnt + 1'b1;
      end
      if (strobe && result.last_bin) begin
        busy <= 1'b0;
      end
    end
  end

  assign cv[0]    = rd_valid;
  assign cd[0].re = 24'(signed'(rd_word[31:16]));
  assign cd[0].im = 24'(signed'(rd_word[15:0]));

  for (genvar g = 0; g < LOG; g++) begin : g_cell
    r2fft_cell #(
      .POINTS (POINTS),
      .HALF   (1 << g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .inv       (frame_inv),
      .in_valid  (cv[g]),
      .in_data   (cd[g]),
      .out_valid (cv[g+1]),
      .out_data  (cd[g+1])
    );
  end

  // Inverse transforms divide by the point count with a flooring shift.
  always_ff @(posedge clk) begin
    result.bin_real <= frame_inv ? (cd[LOG].re >>> LOG) : cd[LOG].re;
    result.bin_imag <= frame_inv ? (cd[LOG].im >>> LOG) : cd[LOG].im;
    result.last_bin <= (out_cnt == LOG'(POINTS - 1));
  end

endmodule

>>> tb/sv/tb_radix2_fft_complex_unit.sv
// Self-checking testbench for the radix-2 FFT unit: directed table, random frames, bin checks.
module tb_radix2_fft_complex_unit;

  localparam int NPTS = 64;
  localparam int LOG2N = 6;
  localparam int N_RANDOM = 180;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  r2fft_pkg::sample_t sample = '0;
  logic               busy;
  logic               cfg_write = 1'b0;
  logic               cfg_data = 1'b0;
  logic               strobe;
  r2fft_pkg::bin_t    result;

  radix2_fft_complex_unit #(.POINTS(NPTS)) u_top (
    .clk(clk), .rst(rst), .start(start), .sample(sample), .busy(busy),
    .cfg_write(cfg_write), .cfg_data(cfg_data), .strobe(strobe), .result(result)
  );

  always #1 clk = ~clk;

  // Predictor state.
  logic signed [23:0] fft_re [0:NPTS-1];
  logic signed [23:0] fft_im [0:NPTS-1];
  int   frame_fill = 0;
  logic inverse_shadow = 1'b0;
  r2fft_pkg::bin_t expected_bins [$];
  int   mismatch_count = 0;

  function automatic logic signed [31:0] twiddle_sin(input int t);
    int tab [0:16] = '{0, 3212, 6393, 9512, 12540, 15447, 18205, 20788, 23170,
                       25330, 27246, 28899, 30274, 31357, 32138, 32610, 32767};
    int q;
    int r;
    q = (t >> 4) & 3;
    r = t & 15;
    case (q)
      0: return tab[r];
      1: return tab[16 - r];
      2: return -tab[r];
      default: return -tab[16 - r];
    endcase
  endfunction

  function automatic logic signed [23:0] clip24(input longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic int bitrev(input int x);
    int r;
    r = 0;
    for (int i = 0; i < LOG2N; i++) r = (r << 1) | ((x >> i) & 1);
    return r;
  endfunction

  // Loads one sample into the predictor; on the last one runs the transform
  // and queues every bin.
  task automatic predict_sample(input r2fft_pkg::sample_t s);
    longint ar, ai, br, bi, wr, wi, pr, pi;
    int ia, ib, t, stride;
    r2fft_pkg::bin_t b;
    fft_re[bitrev(frame_fill)] = 24'(s.sample_real);
    fft_im[bitrev(frame_fill)] = 24'(s.sample_imag);
    if (frame_fill + 1 < NPTS) begin
      frame_fill++;
      return;
    end
    frame_fill = 0;
    for (int half = 1; half < NPTS; half <<= 1) begin
      stride = 64 / (2 * half);
      for (int base = 0; base < NPTS; base += 2 * half) begin
        for (int m = 0; m < half; m++) begin
          ia = base + m;
          ib = base + m + half;
          t = (m * stride) & 63;
          wr = twiddle_sin((t + 16) & 63);
          wi = inverse_shadow ? twiddle_sin(t) : -twiddle_sin(t);
          br = fft_re[ib]; bi = fft_im[ib];
          ar = fft_re[ia]; ai = fft_im[ia];
          pr = (br * wr - bi * wi + 16384) >>> 15;
          pi = (br * wi + bi * wr + 16384) >>> 15;
          fft_re[ia] = clip24(ar + pr);
          fft_im[ia] = clip24(ai + pi);
          fft_re[ib] = clip24(ar - pr);
          fft_im[ib] = clip24(ai - pi);
        end
      end
    end
    for (int k = 0; k < NPTS; k++) begin
      if (inverse_shadow) begin
        fft_re[k] = fft_re[k] >>> LOG2N;
        fft_im[k] = fft_im[k] >>> LOG2N;
      end
      b.bin_real = fft_re[k];
      b.bin_imag = fft_im[k];
      b.last_bin = (k == NPTS - 1);
      expected_bins.push_back(b);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    r2fft_pkg::bin_t want;
    if (!rst && strobe) begin
      if (expected_bins.size() == 0) begin
        report_mismatch("unexpected bin", 1, 0);
      end else begin
        want = expected_bins.pop_front();
        if (result.bin_real !== want.bin_real)
          report_mismatch("bin_real", result.bin_real, want.bin_real);
        if (result.bin_imag !== want.bin_imag)
          report_mismatch("bin_imag", result.bin_imag, want.bin_imag);
        if (result.last_bin !== want.last_bin)
          report_mismatch("last_bin", result.last_bin, want.last_bin);
      end
    end
  end

  // Sends one sample transaction, with an optional gap first. Start stays
  // high between back-to-back transactions.
  task automatic send_sample(input r2fft_pkg::sample_t s, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_sample(s);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (2 * NPTS + 4 * LOG2N + 8) @(posedge clk);
  endtask

  task automatic set_mode(input logic inv);
    cfg_write <= 1'b1;
    cfg_data <= inv;
    @(posedge clk);
    cfg_write <= 1'b0;
    inverse_shadow = inv;
  endtask

  function automatic r2fft_pkg::sample_t rand_sample(input int kind);
    r2fft_pkg::sample_t s;
    case (kind)
      0: s = {16'sh7FFF, 16'sh7FFF};
      1: s = {16'sh8000, 16'sh8000};
      2: s = {16'sh7FFF, 16'sh8000};
      3: begin
        s.sample_real = 16'($urandom_range(0, 15) - 8);
        s.sample_imag = 16'($urandom_range(0, 15) - 8);
      end
      default: s = $urandom;
    endcase
    return s;
  endfunction

  r2fft_pkg::sample_t directed_rows [0:7] = '{
    {16'sh0000, 16'sh0000}, {16'sh7FFF, 16'sh0000}, {16'sh8000, 16'sh0000},
    {16'sh0000, 16'sh7FFF}, {16'sh0000, 16'sh8000}, {16'sh7FFF, 16'sh7FFF},
    {16'sh8000, 16'sh8000}, {16'sh5555, 16'shAAAA}
  };

  initial begin
    int burst;
    int sent;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: all-zero frame after reset, then impulse and full-scale frames.
    for (int i = 0; i < NPTS; i++) send_sample(directed_rows[0], 0);
    wait_idle();
    for (int i = 0; i < NPTS; i++) send_sample(i == 0 ? directed_rows[1] : directed_rows[0], 0);
    wait_idle();
    set_mode(1'b1);
    for (int i = 0; i < NPTS; i++) send_sample(directed_rows[5 + (i & 1)], 0);
    wait_idle();
    set_mode(1'b0);
    // Forward: a frame cycling through directed rows 1 to 7, then a full-scale DC frame.
    for (int i = 0; i < NPTS; i++) send_sample(directed_rows[1 + (i % 7)], 0);
    wait_idle();
    for (int i = 0; i < NPTS; i++) send_sample(directed_rows[6], 0);
    wait_idle();
    // Random frames; the mode is chosen afresh while the unit is idle.
    sent = 0;
    while (sent < N_RANDOM || frame_fill != 0) begin
      int kind;
      kind = $urandom_range(0, 9);
      if (frame_fill == 0) begin
        wait_idle();
        set_mode(1'($urandom_range(0, 1)));
      end
      burst = $urandom_range(1, 12);
      for (int j = 0; j < burst && (sent < N_RANDOM || frame_fill != 0); j++) begin
        send_sample(rand_sample(kind < 2 ? kind : (kind < 4 ? kind : 4)),
                    (j == 0) ? $urandom_range(0, 6) : 0);
        sent++;
      end
    end
    wait_idle();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
